// File: src/imhq_pkg.sv
// Shared types, codes and defaults for the indexed min-heap queue.
`default_nettype none
package imhq_pkg;

  localparam int unsigned CAPACITY_DEF  = 256;
  localparam int unsigned ID_COUNT_DEF  = 256;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned KEYIN_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W    = 9;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 3'd0,
    MODE_POP   = 3'd1,
    MODE_PEEK  = 3'd2,
    MODE_FIND  = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_RETURNED = 3'd2,
    ST_MISS     = 3'd3,
    ST_FULL     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_MAP_RD,
    S_MAP_WAIT,
    S_DISPATCH,
    S_ROOT_RD,
    S_ROOT_WAIT,
    S_POP_LAST_RD,
    S_POP_LAST_WAIT,
    S_POP_WR,
    S_FIND_RD,
    S_FIND_WAIT,
    S_UP_RD,
    S_UP_WAIT,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_WAITR,
    S_DN_CMP,
    S_DN_WR2,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: src/indexed_min_heap_queue_top.sv
// Indexed binary min-heap priority queue: top level with sequencer and memories.
//
// Input channel in_*: one request per accepted beat, tdata = {entry_key, entry_id},
// tuser = mode (push/update, pop, peek, find, clear). Output channel out_*: one
// response per request, tdata = {occupancy, result_key, result_id}, tuser = status.
// The block takes one request at a time: in_tready is high only when idle and the
// output register is free. A request without heap access (miss, drop, unused mode)
// answers after the map read; peek and find read the heap once. Push sifts up level
// by level; pop reads the root and the last entry, moves the last entry to the root
// and sifts it down; an update sifts down and then up. Every compare waits on the
// registered heap RAM read for each entry it needs.
// After reset the position map is swept clear, one entry a cycle; in_tready is low
// during the sweep. Clear requests run the same sweep and then answer with an
// empty heap.
// The response sits in an output register until out_tready takes it; while it
// waits, no new request is accepted. in_tready rises the cycle after it is taken.
`default_nettype none
module indexed_min_heap_queue_top #(
  parameter int unsigned CAPACITY  = imhq_pkg::CAPACITY_DEF,
  parameter int unsigned ID_COUNT  = imhq_pkg::ID_COUNT_DEF,
  parameter int unsigned KEY_WIDTH = imhq_pkg::KEY_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // entry_id[7:0], entry_key[39:8]
  input  wire logic [2:0]  in_tuser,   // mode[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // result_id[7:0], result_key[39:8], occupancy[48:40]
  output logic [2:0]       out_tuser   // status[2:0]
);
  import imhq_pkg::*;

  localparam int unsigned PW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned IW  = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int unsigned MW  = CW;            // map: position plus one
  localparam int unsigned HW  = IW + KEY_WIDTH;
  localparam int unsigned XW  = CW + 1;        // room for 2*pos+2

  state_t state_r, state_nxt;

  // registers
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;      // position of the moving entry
  logic [PW-1:0]        oth_r, oth_nxt;      // parent or chosen child
  logic [IW-1:0]        oid_r, oid_nxt;
  logic [KEY_WIDTH-1:0] okey_r, okey_nxt;
  logic [IW-1:0]        lid_r, lid_nxt;      // left child while right is read
  logic [KEY_WIDTH-1:0] lkey_r, lkey_nxt;
  logic                 upd_r, upd_nxt;      // update: down then up
  logic [IW:0]          clr_r, clr_nxt;
  logic [STATUS_W-1:0]  st_r, st_nxt;
  logic [ID_W-1:0]      rid_r, rid_nxt;
  logic [KEYIN_W-1:0]   rkey_r, rkey_nxt;
  logic                 ov_r, ov_nxt;
  logic [STATUS_W-1:0]  ost_r, ost_nxt;
  logic [ID_W-1:0]      orid_r, orid_nxt;
  logic [KEYIN_W-1:0]   orkey_r, orkey_nxt;
  logic [OCC_W-1:0]     oocc_r, oocc_nxt;

  // heap RAM
  logic          h_we;
  logic [PW-1:0] h_wa, h_ra;
  logic [HW-1:0] h_wd, h_rd;
  // map RAM
  logic          m_we;
  logic [IW-1:0] m_wa, m_ra;
  logic [MW-1:0] m_wd, m_rd;

  imhq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  imhq_ram #(.WIDTH(MW), .DEPTH(ID_COUNT)) u_map (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));

  logic [IW-1:0]        rd_id;
  logic [KEY_WIDTH-1:0] rd_key;
  assign rd_id  = h_rd[HW-1:KEY_WIDTH];
  assign rd_key = h_rd[KEY_WIDTH-1:0];

  logic          id_ok;
  logic [IW-1:0] id_ix;
  assign id_ok = ({24'd0, id_r} < 32'(ID_COUNT));
  assign id_ix = IW'(id_r);

  logic [XW-1:0] lc, rc;
  assign lc = XW'({pos_r, 1'b1});
  assign rc = lc + XW'(1);

  logic [CW-1:0] cnt_m1;
  assign cnt_m1 = cnt_r - CW'(1);

  logic          accept;
  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign accept    = in_tvalid && in_tready;

  // position-plus-one helper
  function automatic logic [MW-1:0] pp1(input logic [PW-1:0] p);
    pp1 = MW'(p) + MW'(1);
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (accept) state_nxt = S_MAP_RD;
      S_CLR: begin
        // a clear request answers after the sweep; the reset sweep does not
        if (clr_r == (IW+1)'(ID_COUNT - 1)) begin
          state_nxt = (st_r == ST_CLEARED) ? S_DONE : S_IDLE;
        end
      end
      S_MAP_RD:    state_nxt = S_MAP_WAIT;
      S_MAP_WAIT:  state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        state_nxt = S_DONE;
        case (mode_r)
          MODE_PUSH: begin
            if (id_ok && m_rd != '0) state_nxt = S_DN_RDL;
            else if (id_ok && cnt_r < CW'(CAPACITY)) state_nxt = S_UP_RD;
          end
          MODE_POP:   if (cnt_r != '0) state_nxt = S_ROOT_RD;
          MODE_PEEK:  if (cnt_r != '0) state_nxt = S_ROOT_RD;
          MODE_FIND:  if (id_ok && m_rd != '0) state_nxt = S_FIND_RD;
          MODE_CLEAR: state_nxt = S_CLR;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_ROOT_RD:   state_nxt = S_ROOT_WAIT;
      S_ROOT_WAIT: state_nxt = (mode_r == MODE_POP) ? S_POP_LAST_RD : S_DONE;
      S_POP_LAST_RD:   state_nxt = S_POP_LAST_WAIT;
      S_POP_LAST_WAIT: state_nxt = S_POP_WR;
      S_POP_WR:    state_nxt = S_DN_RDL;
      S_FIND_RD:   state_nxt = S_FIND_WAIT;
      S_FIND_WAIT: state_nxt = S_DONE;
      S_UP_RD:     state_nxt = (pos_r == '0) ? S_DONE : S_UP_WAIT;
      S_UP_WAIT:   state_nxt = S_UP_CMP;
      S_UP_CMP:    state_nxt = (key_r < rd_key) ? S_UP_RD : S_DONE;
      S_DN_RDL: begin
        if (XW'(lc) >= XW'(cnt_r)) state_nxt = upd_r ? S_UP_RD : S_DONE;
        else state_nxt = S_DN_RDR;
      end
      S_DN_RDR:    state_nxt = S_DN_WAITR;
      S_DN_WAITR:  state_nxt = S_DN_CMP;
      S_DN_CMP: begin
        if (okey_nxt < key_r) state_nxt = S_DN_WR2;
        else state_nxt = upd_r ? S_UP_RD : S_DONE;
      end
      S_DN_WR2:    state_nxt = S_DN_RDL;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r; mode_nxt = mode_r; id_nxt = id_r; key_nxt = key_r;
    pos_nxt = pos_r; oth_nxt = oth_r; oid_nxt = oid_r; okey_nxt = okey_r;
    lid_nxt = lid_r; lkey_nxt = lkey_r; upd_nxt = upd_r; clr_nxt = clr_r;
    st_nxt = st_r; rid_nxt = rid_r; rkey_nxt = rkey_r;
    ov_nxt = ov_r; ost_nxt = ost_r; orid_nxt = orid_r; orkey_nxt = orkey_r;
    oocc_nxt = oocc_r;
    h_we = 1'b0; h_wa = pos_r; h_wd = {id_ix, key_r}; h_ra = pos_r;
    m_we = 1'b0; m_wa = id_ix; m_wd = pp1(pos_r); m_ra = id_ix;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt = in_tuser;
          id_nxt   = in_tdata[7:0];
          key_nxt  = KEY_WIDTH'(in_tdata[39:8]);
          st_nxt   = ST_MISS; rid_nxt = '0; rkey_nxt = '0; upd_nxt = 1'b0;
        end
      end
      S_CLR: begin
        m_we = 1'b1; m_wa = clr_r[IW-1:0]; m_wd = '0;
        clr_nxt = clr_r + (IW+1)'(1);
      end
      S_MAP_RD: m_ra = id_ix;
      S_DISPATCH: begin
        case (mode_r)
          MODE_PUSH: begin
            if (!id_ok) st_nxt = ST_FULL;
            else if (m_rd != '0) begin
              st_nxt = ST_UPDATED; upd_nxt = 1'b1;
              pos_nxt = PW'(m_rd - MW'(1));
              h_we = 1'b1; h_wa = PW'(m_rd - MW'(1)); h_wd = {id_ix, key_r};
            end else if (cnt_r < CW'(CAPACITY)) begin
              st_nxt = ST_INSERTED;
              pos_nxt = PW'(cnt_r);
              h_we = 1'b1; h_wa = PW'(cnt_r); h_wd = {id_ix, key_r};
              m_we = 1'b1; m_wa = id_ix; m_wd = MW'(cnt_r) + MW'(1);
              cnt_nxt = cnt_r + CW'(1);
            end else st_nxt = ST_FULL;
          end
          MODE_FIND:  if (id_ok && m_rd != '0) pos_nxt = PW'(m_rd - MW'(1));
          MODE_CLEAR: begin
            st_nxt = ST_CLEARED; cnt_nxt = '0; clr_nxt = '0;
          end
          default: ;
        endcase
      end
      S_ROOT_RD: h_ra = '0;
      S_ROOT_WAIT: begin
        st_nxt = ST_RETURNED;
        rid_nxt = ID_W'(rd_id); rkey_nxt = KEYIN_W'(rd_key);
        id_nxt = ID_W'(rd_id);
      end
      S_POP_LAST_RD: h_ra = PW'(cnt_m1);
      S_POP_LAST_WAIT: begin
        // removed id leaves the map; last entry becomes the moving one
        m_we = 1'b1; m_wa = IW'(rid_r); m_wd = '0;
        key_nxt = rd_key; oid_nxt = rd_id;
        cnt_nxt = cnt_m1; pos_nxt = '0;
      end
      S_POP_WR: begin
        id_nxt = ID_W'(oid_r);
        if (cnt_r != '0) begin
          h_we = 1'b1; h_wa = '0; h_wd = {oid_r, key_r};
          m_we = 1'b1; m_wa = oid_r; m_wd = MW'(1);
        end
      end
      S_FIND_RD: h_ra = pos_r;
      S_FIND_WAIT: begin
        st_nxt = ST_RETURNED;
        rid_nxt = ID_W'(rd_id); rkey_nxt = KEYIN_W'(rd_key);
      end
      S_UP_RD: begin
        oth_nxt = PW'((pos_r - PW'(1)) >> 1);
        h_ra = PW'((pos_r - PW'(1)) >> 1);
        if (pos_r == '0) begin
          // reached the root: the moving entry settles here
          h_we = 1'b1;
          m_we = 1'b1;
        end
      end
      S_UP_WAIT: h_ra = oth_r;
      S_UP_CMP: begin
        if (key_r < rd_key) begin
          // parent moves down, entry moves up
          h_we = 1'b1; h_wa = pos_r; h_wd = h_rd;
          m_we = 1'b1; m_wa = rd_id; m_wd = pp1(pos_r);
          pos_nxt = oth_r;
          oid_nxt = rd_id;
        end else begin
          h_we = 1'b1;
          m_we = 1'b1;
        end
      end
      S_DN_RDL: h_ra = PW'(lc);
      S_DN_RDR: begin
        h_ra = PW'(rc);
        lid_nxt = rd_id; lkey_nxt = rd_key;
      end
      S_DN_WAITR: h_ra = PW'(rc);
      S_DN_CMP: begin
        if (XW'(rc) < XW'(cnt_r) && rd_key < lkey_r) begin
          oth_nxt = PW'(rc); oid_nxt = rd_id; okey_nxt = rd_key;
        end else begin
          oth_nxt = PW'(lc); oid_nxt = lid_r; okey_nxt = lkey_r;
        end
        if (okey_nxt < key_r) begin
          h_we = 1'b1; h_wa = pos_r; h_wd = {oid_nxt, okey_nxt};
          m_we = 1'b1; m_wa = oid_nxt; m_wd = pp1(pos_r);
        end
      end
      S_DN_WR2: begin
        pos_nxt = oth_r;
        h_we = 1'b1; h_wa = oth_r; h_wd = {id_ix, key_r};
        m_we = 1'b1; m_wa = id_ix; m_wd = pp1(oth_r);
      end
      S_DONE: begin
        ov_nxt = 1'b1; ost_nxt = st_r; orid_nxt = rid_r; orkey_nxt = rkey_r;
        oocc_nxt = OCC_W'(cnt_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      st_r    <= ST_MISS;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      st_r    <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt; id_r <= id_nxt; key_r <= key_nxt; pos_r <= pos_nxt;
    oth_r <= oth_nxt; oid_r <= oid_nxt; okey_r <= okey_nxt;
    lid_r <= lid_nxt; lkey_r <= lkey_nxt; upd_r <= upd_nxt;
    rid_r <= rid_nxt; rkey_r <= rkey_nxt;
    ost_r <= ost_nxt; orid_r <= orid_nxt; orkey_r <= orkey_nxt; oocc_r <= oocc_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ost_r;
  assign out_tdata  = {7'd0, oocc_r, orkey_r, orid_r};
endmodule
`default_nettype wire

// File: src/imhq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module imhq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: src/imhq_checker.sv
// Port-level checker for the indexed min-heap queue, bound to the top level.
`default_nettype none
module imhq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic [2:0]  out_tuser
);
  import imhq_pkg::*;

  // a response holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("response dropped or changed while stalled");

  // no new request while a response waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while response pending");

  // an accepted request is followed by a quiet cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !out_tvalid)
    else $error("overlapping requests");

  // cleared status reports an empty heap
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_CLEARED |-> out_tdata[48:40] == 9'd0)
    else $error("clear left entries");
endmodule

bind indexed_min_heap_queue_top imhq_checker u_imhq_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser));
`default_nettype wire
